[sv/filtered_speed_pi_loop_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef FILTERED_SPEED_PI_LOOP_MACROS_SVH
`define FILTERED_SPEED_PI_LOOP_MACROS_SVH

// same-cycle implication
`define FSP_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

[sv/fsp_pkg.sv]
package fsp_pkg;

  localparam int CNT_W      = 16;
  localparam int SUM_W      = 17;
  localparam int SPD_W      = 32;
  localparam int DRV_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 16;
  localparam int MUL_LEN_W  = 5;
  localparam int ACC_W      = 50;

  localparam int LP_SHIFT   = 8;
  localparam int OUT_SHIFT  = 16;
  localparam int LIM_SHIFT  = 8;

  localparam logic [MUL_B_W-1:0]   LP_OLD   = 16'd179;
  localparam logic [MUL_B_W-1:0]   LP_NEW   = 16'd77;
  localparam logic [MUL_LEN_W-1:0] LEN_FULL = 5'd16;
  localparam logic [MUL_LEN_W-1:0] LEN_LP   = 5'd8;

  localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd3;

  typedef struct packed {
    logic                 start;
    logic                 accum;
    logic                 b_signed;
    logic [MUL_LEN_W-1:0] len;
  } mul_cmd_t;

endpackage

[sv/fsp_ram.sv]
module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/fsp_smul.sv]
module fsp_smul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fsp_pkg::mul_cmd_t                   cmd_i,
  input  logic signed [fsp_pkg::MUL_A_W-1:0]  a_i,
  input  logic        [fsp_pkg::MUL_B_W-1:0]  b_i,
  output logic                                done_o,
  output logic signed [fsp_pkg::ACC_W-1:0]    acc_o
);

  import fsp_pkg::*;

  localparam int SH_W = MUL_A_W + MUL_B_W - 1;

  logic signed [SH_W-1:0]  a_sh_q;
  logic [MUL_B_W-1:0]      b_sh_q;
  logic [MUL_LEN_W-1:0]    cnt_q;
  logic                    busy_q;
  logic                    done_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] pp;
  logic signed [ACC_W-1:0] acc_d;
  logic                    last;

  // one multiplier bit per cycle, lsb first; msb of a signed operand has negative weight
  assign last  = (cnt_q == MUL_LEN_W'(1));
  assign pp    = b_sh_q[0] ? {{(ACC_W-SH_W){a_sh_q[SH_W-1]}}, a_sh_q} : '0;
  assign acc_d = (last && neg_q) ? acc_q - pp : acc_q + pp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cmd_i.len;
      neg_q  <= cmd_i.b_signed;
    end else if (busy_q) begin
      cnt_q <= cnt_q - MUL_LEN_W'(1);
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_sh_q <= {{(SH_W-MUL_A_W){a_i[MUL_A_W-1]}}, a_i};
      b_sh_q <= b_i;
      if (!cmd_i.accum) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q  <= acc_d;
      a_sh_q <= a_sh_q <<< 1;
      b_sh_q <= b_sh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

[sv/filtered_speed_pi_loop.sv]
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   left_count_i, right_count_i
// out      output     out_valid_o / out_ready_i drive_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// an item passes in order through sample scaling, window subtract, window add, two
// smoothing products, smoothing, integral clamp, the proportional and integral
// products and the output register, all products on the shared bit-serial multiplier
// of 16, 8, 8, 16, 16 bits; in_ready_o rises in the cycle after the result registers
// in_ready_o is high only while idle; a result waiting on out_ready_i holds the
// next item in its final cycle until the output register frees
// asynchronous active-low reset clears the filters, the integral and the window
// fill flag; no clearing pass, cfg_ready_o is always high
module filtered_speed_pi_loop #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [fsp_pkg::CNT_W-1:0]      left_count_i,
  input  logic signed [fsp_pkg::CNT_W-1:0]      right_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fsp_pkg::DRV_W-1:0]      drive_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [fsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [fsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import fsp_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LEN);
  localparam int TOT_W = SPD_W + POS_W;
  localparam int Q_W   = ACC_W - OUT_SHIFT;
  localparam int ISUM_W = SPD_W + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MSAMP  = 4'd1;
  localparam logic [3:0] ST_WSUB   = 4'd2;
  localparam logic [3:0] ST_WADD   = 4'd3;
  localparam logic [3:0] ST_MOLD   = 4'd4;
  localparam logic [3:0] ST_MNEW   = 4'd5;
  localparam logic [3:0] ST_SMOOTH = 4'd6;
  localparam logic [3:0] ST_INTEG  = 4'd7;
  localparam logic [3:0] ST_MPROP  = 4'd8;
  localparam logic [3:0] ST_MINTG  = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0]              state_q;
  logic [GAIN_W-1:0]       rpm_scale_q;
  logic signed [GAIN_W-1:0] prop_gain_q;
  logic signed [GAIN_W-1:0] integ_gain_q;
  logic [LIM_W-1:0]        integ_limit_q;
  logic [POS_W-1:0]        pos_q;
  logic                    wrapped_q;
  logic signed [TOT_W-1:0] total_q;
  logic signed [SPD_W-1:0] smoothed_q;
  logic signed [SPD_W-1:0] integral_q;
  logic                    out_valid_q;
  logic signed [DRV_W-1:0] drive_q;

  logic                    in_fire;
  logic                    out_free;
  logic signed [SUM_W-1:0] sum_w;
  mul_cmd_t                mul_cmd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic                    mul_done;
  logic signed [ACC_W-1:0] acc;
  logic [SPD_W-1:0]        ram_rdata;
  logic signed [SPD_W-1:0] sample_w;
  logic signed [SPD_W-1:0] old_w;
  logic signed [SPD_W-1:0] mean_w;
  logic signed [SPD_W-1:0] smooth_w;
  logic signed [ISUM_W-1:0] isum_w;
  logic signed [ISUM_W-1:0] lim_w;
  logic signed [ISUM_W-1:0] nlim_w;
  logic signed [SPD_W-1:0] integ_w;
  logic signed [Q_W-1:0]   q_w;
  logic signed [DRV_W-1:0] drive_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  assign sum_w = {left_count_i[CNT_W-1], left_count_i} + {right_count_i[CNT_W-1], right_count_i};

  // saturate the scaled sample to 32 bits
  always_comb begin
    if (acc[ACC_W-1]) begin
      sample_w = (&acc[ACC_W-1:SPD_W-1]) ? acc[SPD_W-1:0] : {1'b1, {(SPD_W-1){1'b0}}};
    end else begin
      sample_w = (~|acc[ACC_W-1:SPD_W-1]) ? acc[SPD_W-1:0] : {1'b0, {(SPD_W-1){1'b1}}};
    end
  end

  assign old_w    = wrapped_q ? ram_rdata : '0;
  assign mean_w   = total_q[TOT_W-1:POS_W];
  assign smooth_w = acc[SPD_W+LP_SHIFT-1:LP_SHIFT];

  // integral clamp to +/- limit, the limit counted in units of 256
  assign isum_w = {integral_q[SPD_W-1], integral_q} + {smoothed_q[SPD_W-1], smoothed_q};
  assign lim_w  = {{(ISUM_W-LIM_W-LIM_SHIFT){1'b0}}, integ_limit_q, {LIM_SHIFT{1'b0}}};
  assign nlim_w = -lim_w;

  always_comb begin
    if (isum_w > lim_w) begin
      integ_w = lim_w[SPD_W-1:0];
    end else if (isum_w < nlim_w) begin
      integ_w = nlim_w[SPD_W-1:0];
    end else begin
      integ_w = isum_w[SPD_W-1:0];
    end
  end

  // truncate toward zero, then saturate to the drive width
  assign q_w = acc[ACC_W-1:OUT_SHIFT] + Q_W'(acc[ACC_W-1] && (|acc[OUT_SHIFT-1:0]));

  always_comb begin
    if (q_w[Q_W-1]) begin
      drive_w = (&q_w[Q_W-1:DRV_W-1]) ? q_w[DRV_W-1:0] : {1'b1, {(DRV_W-1){1'b0}}};
    end else begin
      drive_w = (~|q_w[Q_W-1:DRV_W-1]) ? q_w[DRV_W-1:0] : {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  always_comb begin
    mul_cmd = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mul_cmd.start = 1'b1;
          mul_cmd.len   = LEN_FULL;
          mul_a         = {{(MUL_A_W-SUM_W){sum_w[SUM_W-1]}}, sum_w};
          mul_b         = rpm_scale_q;
        end
      end
      ST_WADD: begin
        mul_cmd.start = 1'b1;
        mul_cmd.len   = LEN_LP;
        mul_a         = smoothed_q;
        mul_b         = LP_OLD;
      end
      ST_MOLD: begin
        if (mul_done) begin
          mul_cmd.start = 1'b1;
          mul_cmd.accum = 1'b1;
          mul_cmd.len   = LEN_LP;
          mul_a         = mean_w;
          mul_b         = LP_NEW;
        end
      end
      ST_INTEG: begin
        mul_cmd.start    = 1'b1;
        mul_cmd.b_signed = 1'b1;
        mul_cmd.len      = LEN_FULL;
        mul_a            = smoothed_q;
        mul_b            = prop_gain_q;
      end
      ST_MPROP: begin
        if (mul_done) begin
          mul_cmd.start    = 1'b1;
          mul_cmd.accum    = 1'b1;
          mul_cmd.b_signed = 1'b1;
          mul_cmd.len      = LEN_FULL;
          mul_a            = integral_q;
          mul_b            = integ_gain_q;
        end
      end
      default: begin
      end
    endcase
  end

  fsp_smul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .acc_o  (acc)
  );

  fsp_ram #(
    .WIDTH (SPD_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WSUB),
    .waddr_i (pos_q),
    .wdata_i (sample_w),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_scale_q   <= 16'd256;
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      integ_limit_q <= 23'd6000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RPM_SCALE:   rpm_scale_q   <= cfg_data_i[GAIN_W-1:0];
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pos_q      <= '0;
      wrapped_q  <= 1'b0;
      total_q    <= '0;
      smoothed_q <= '0;
      integral_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_MSAMP;
          end
        end
        ST_MSAMP: begin
          if (mul_done) begin
            state_q <= ST_WSUB;
          end
        end
        ST_WSUB: begin
          total_q <= total_q - {{POS_W{old_w[SPD_W-1]}}, old_w};
          state_q <= ST_WADD;
        end
        ST_WADD: begin
          total_q <= total_q + {{POS_W{sample_w[SPD_W-1]}}, sample_w};
          pos_q   <= pos_q + POS_W'(1);
          if (&pos_q) begin
            wrapped_q <= 1'b1;
          end
          state_q <= ST_MOLD;
        end
        ST_MOLD: begin
          if (mul_done) begin
            state_q <= ST_MNEW;
          end
        end
        ST_MNEW: begin
          if (mul_done) begin
            state_q <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          smoothed_q <= smooth_w;
          state_q    <= ST_INTEG;
        end
        ST_INTEG: begin
          integral_q <= integ_w;
          state_q    <= ST_MPROP;
        end
        ST_MPROP: begin
          if (mul_done) begin
            state_q <= ST_MINTG;
          end
        end
        ST_MINTG: begin
          if (mul_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      drive_q <= drive_w;
    end
  end

endmodule

[sv/fsp_chk.sv]
`include "filtered_speed_pi_loop_macros.svh"

module fsp_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [fsp_pkg::DRV_W-1:0] drive_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o
);

  logic in_fire;
  logic cfg_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  // one item at a time
  `FSP_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "input taken while busy")

  // serial work keeps the input closed well into the item
  `FSP_ASSERT_NEXT(a_busy_long, in_fire, ##40 !in_ready_o, "item finished too early")

  // a new result appears only as the block returns to idle
  `FSP_ASSERT_NOW(a_result_idle, $rose(out_valid_o), in_ready_o && !$past(in_ready_o), "result without completed item")

  // a stalled result holds
  `FSP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(drive_o), "stalled result changed")

  // configuration is never back-pressured
  `FSP_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_fire, "configuration write refused")

endmodule

bind filtered_speed_pi_loop fsp_chk u_fsp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_o     (drive_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

[test/tb_top.sv]
module tb_top;
  import fsp_pkg::*;

  localparam int WIN_LEN     = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int DIR_A       = 12;
  localparam int DIR_N       = 20;

  class drive_scoreboard;
    localparam longint KEEP       = 179;
    localparam longint BLEND      = 77;
    localparam longint SAMPLE_MAX = 64'sd2147483647;
    localparam longint SAMPLE_MIN = -64'sd2147483648;
    localparam longint DRIVE_MAX  = 64'sd8388607;
    localparam longint DRIVE_MIN  = -64'sd8388608;

    logic        [15:0] rpm_scale;
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic        [22:0] integ_limit;

    longint      speed_window[WIN_LEN];
    longint      window_total;
    int unsigned window_pos;
    longint      smoothed_speed;
    longint      integral;

    logic signed [DRV_W-1:0] pending_drives[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned sample_sats;
    int unsigned integ_clamps;
    int unsigned drive_sats;

    function new();
      rpm_scale = 16'd256;
      prop_gain = '0;
      integ_gain = '0;
      integ_limit = 23'd6000;
      foreach (speed_window[i]) speed_window[i] = 0;
      window_total = 0;
      window_pos = 0;
      smoothed_speed = 0;
      integral = 0;
      errors = 0;
      checked = 0;
      sample_sats = 0;
      integ_clamps = 0;
      drive_sats = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RPM_SCALE:   rpm_scale = data[15:0];
        REG_PROP_GAIN:   prop_gain = data[15:0];
        REG_INTEG_GAIN:  integ_gain = data[15:0];
        REG_INTEG_LIMIT: integ_limit = data[22:0];
        default: ;
      endcase
    endfunction

    function void note_counts(logic signed [CNT_W-1:0] left, logic signed [CNT_W-1:0] right);
      longint sample;
      longint mean;
      longint lim;
      longint acc;
      longint drive;
      sample = (longint'(left) + longint'(right)) * longint'(rpm_scale);
      if (sample > SAMPLE_MAX) begin
        sample = SAMPLE_MAX;
        sample_sats++;
      end else if (sample < SAMPLE_MIN) begin
        sample = SAMPLE_MIN;
        sample_sats++;
      end
      window_total = window_total - speed_window[window_pos] + sample;
      speed_window[window_pos] = sample;
      window_pos = (window_pos + 1) % WIN_LEN;
      mean = window_total >>> $clog2(WIN_LEN);
      smoothed_speed = (KEEP * smoothed_speed + BLEND * mean) >>> 8;
      lim = longint'(integ_limit) * 256;
      integral = integral + smoothed_speed;
      if (integral > lim) begin
        integral = lim;
        integ_clamps++;
      end else if (integral < -lim) begin
        integral = -lim;
        integ_clamps++;
      end
      acc = longint'(prop_gain) * smoothed_speed + longint'(integ_gain) * integral;
      drive = acc / 65536;
      if (drive > DRIVE_MAX) begin
        drive = DRIVE_MAX;
        drive_sats++;
      end else if (drive < DRIVE_MIN) begin
        drive = DRIVE_MIN;
        drive_sats++;
      end
      pending_drives.push_back(drive[DRV_W-1:0]);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_drive(logic signed [DRV_W-1:0] got);
      logic signed [DRV_W-1:0] want;
      if (pending_drives.size() == 0) begin
        report($sformatf("drive %0d with no item pending", got));
      end else begin
        want = pending_drives.pop_front();
        checked++;
        if (got !== want) begin
          report($sformatf("drive got %0d expected %0d (result %0d)", got, want, checked));
        end
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [CNT_W-1:0] left_count_i = '0;
  logic signed [CNT_W-1:0] right_count_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [DRV_W-1:0] drive_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  drive_scoreboard sb = new();
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned settings_loaded = 0;
  int unsigned items_sent = 0;

  int dir_left[DIR_N] = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767,
                          0, 1, 0, -1,
                          -3, 5, 0, -1, 100, 7, -32768, 3};
  int dir_right[DIR_N] = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768,
                           0, 0, -1, -1,
                           0, -9, 1, 0, -300, 7, -32768, -2};

  always #2 clk_i = ~clk_i;

  filtered_speed_pi_loop #(
    .WINDOW_LEN(WIN_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_count_i (left_count_i),
    .right_count_i(right_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  task automatic load_settings(input logic [15:0] scale, input logic signed [15:0] prop,
                               input logic signed [15:0] igain, input logic [22:0] limit);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] data[4];
    idx = '{REG_RPM_SCALE, REG_PROP_GAIN, REG_INTEG_GAIN, REG_INTEG_LIMIT};
    data[0] = {7'($urandom), scale};
    data[1] = {7'($urandom), prop};
    data[2] = {7'($urandom), igain};
    data[3] = limit;
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= data[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_counts(input logic signed [CNT_W-1:0] left,
                             input logic signed [CNT_W-1:0] right);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_count_i <= left;
    right_count_i <= right;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_counts(left, right);
    items_sent++;
  endtask

  task automatic wait_results();
    if (sb.pending_drives.size() != 0) begin
      in_valid_i <= 1'b0;
    end
    while (sb.pending_drives.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CNT_W-1:0] extreme_count();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 11) : 0;
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (out_valid_o !== 1'b1);
        repeat (stall - 1) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_drive(drive_o);
    end
  end

  initial begin
    #4000000;
    $display("filtered_speed_pi_loop regression: fail");
    $finish;
  end

  initial begin
    logic        [15:0]       scale;
    logic signed [15:0]       prop;
    logic signed [15:0]       igain;
    logic        [22:0]       limit;
    logic signed [CNT_W-1:0]  left;
    logic signed [CNT_W-1:0]  right;
    int                       base;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturating samples, tight integral clamp, saturated drive
    load_settings(16'hffff, 16'sh7fff, 16'sh7fff, 23'd2);
    for (int i = 0; i < DIR_A; i++) send_counts(16'(dir_left[i]), 16'(dir_right[i]));
    wait_results();
    // small gains so negative sums truncate toward zero
    load_settings(16'd256, 16'sd1, -16'sd1, 23'd6000);
    for (int i = DIR_A; i < DIR_N; i++) send_counts(16'(dir_left[i]), 16'(dir_right[i]));
    wait_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        load_settings(16'hffff, 16'sh7fff, 16'sh8000, 23'h7fffff);
      end else if (phase == 1) begin
        load_settings(16'h0000, 16'sh8000, 16'sh7fff, 23'd0);
      end else begin
        case ($urandom_range(0, 3))
          0: scale = 16'h0000;
          1: scale = 16'hffff;
          2: scale = 16'($urandom_range(1, 600));
          default: scale = 16'($urandom);
        endcase
        prop = pick_gain();
        igain = pick_gain();
        case ($urandom_range(0, 3))
          0: limit = 23'd0;
          1: limit = 23'h7fffff;
          2: limit = 23'($urandom_range(0, 50));
          default: limit = 23'($urandom);
        endcase
        load_settings(scale, prop, igain, limit);
      end
      tx_gaps_on = (phase % 3 != 1);
      rx_stalls_on = (phase % 3 != 2);
      base = int'($urandom_range(0, 8000)) - 4000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
          wait_results();
        end
        if ($urandom_range(0, 19) == 0) begin
          base = int'($urandom_range(0, 8000)) - 4000;
        end
        case ($urandom_range(0, 9))
          0: begin
            left = extreme_count();
            right = extreme_count();
          end
          1, 2: begin
            left = 16'($urandom);
            right = 16'($urandom);
          end
          default: begin
            left = 16'(base + int'($urandom_range(0, 200)) - 100);
            right = 16'(base + int'($urandom_range(0, 200)) - 100);
          end
        endcase
        send_counts(left, right);
      end
      wait_results();
    end

    repeat (100) @(posedge clk_i);
    $display("covered %0d count pairs under %0d register settings, %0d drive values checked",
             items_sent, settings_loaded, sb.checked);
    $display("saturated samples %0d, clamped integrals %0d, saturated drives %0d",
             sb.sample_sats, sb.integ_clamps, sb.drive_sats);
    if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
      $display("filtered_speed_pi_loop regression: pass");
    end else begin
      $display("filtered_speed_pi_loop regression: fail");
    end
    $finish;
  end

endmodule
